### hw/rtl/six_bit_text_decoder_macros.svh
// assertion macros for the six-bit text decoder
`ifndef SIX_BIT_TEXT_DECODER_MACROS_SVH
`define SIX_BIT_TEXT_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SBTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SBTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/sbtd_pkg.sv
package sbtd_pkg;

  localparam int VALUE_DIGITS = 11;
  localparam int SYM_W = 6;
  localparam int DL_W = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] KIND_TEXT = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;
  localparam logic [1:0] KIND_DBL  = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  localparam logic [2:0] PFX_NONE = 3'd0;
  localparam logic [2:0] PFX_UNI  = 3'd1;
  localparam logic [2:0] PFX_INT  = 3'd2;
  localparam logic [2:0] PFX_DBL  = 3'd3;
  localparam logic [2:0] PFX_END  = 3'd4;

  // one decoded request: up to four text bytes, first byte lowest, or one value
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  cnt;
    logic [31:0] bytes;
    logic [63:0] value;
  } job_t;

  typedef struct packed {
    logic [1:0]  len;
    logic [2:0]  pfx;
    logic [23:0] bytes;
  } esc_t;

  function automatic esc_t e1(input logic [7:0] a);
    esc_t r;
    r = '0;
    r.len = 2'd1;
    r.bytes = {16'h0, a};
    return r;
  endfunction

  function automatic esc_t e2(input logic [7:0] a, input logic [7:0] b);
    esc_t r;
    r = '0;
    r.len = 2'd2;
    r.bytes = {8'h0, b, a};
    return r;
  endfunction

  function automatic esc_t e3(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    esc_t r;
    r = '0;
    r.len = 2'd3;
    r.bytes = {c, b, a};
    return r;
  endfunction

  function automatic esc_t ep(input logic [2:0] p);
    esc_t r;
    r = '0;
    r.pfx = p;
    return r;
  endfunction

  function automatic esc_t esc_entry(input logic [SYM_W-1:0] s);
    esc_t r;
    unique case (s)
      6'd0:  r = e1(8'h2E);
      6'd1:  r = e1(8'h2C);
      6'd2:  r = e1(8'h2D);
      6'd3:  r = e1(8'h5F);
      6'd4:  r = e1(8'h2F);
      6'd5:  r = e1(8'h3A);
      6'd6:  r = e1(8'h3B);
      6'd7:  r = e1(8'h3F);
      6'd8:  r = e1(8'h21);
      6'd9:  r = e1(8'h40);
      6'd10: r = e1(8'h23);
      6'd11: r = e1(8'h24);
      6'd12: r = e1(8'h2B);
      6'd13: r = e1(8'h3D);
      6'd14: r = e1(8'h2A);
      6'd15: r = e1(8'h26);
      6'd16: r = e1(8'h25);
      6'd17: r = e1(8'h5E);
      6'd18: r = e1(8'h28);
      6'd19: r = e1(8'h29);
      6'd20: r = e1(8'h5B);
      6'd21: r = e1(8'h5D);
      6'd22: r = e1(8'h7B);
      6'd23: r = e1(8'h7D);
      6'd24: r = e1(8'h3C);
      6'd25: r = e1(8'h3E);
      6'd26: r = e1(8'h07);
      6'd27: r = e1(8'h08);
      6'd28: r = e1(8'hA9);
      6'd29: r = ep(PFX_DBL);
      6'd30: r = e1(8'h1B);
      6'd31: r = e1(8'h0C);
      6'd32: r = e1(8'hF7);
      6'd33: r = e1(8'hD7);
      6'd34: r = ep(PFX_INT);
      6'd35: r = e2(8'hC2, 8'hAB);
      6'd36: r = e2(8'hC2, 8'hBB);
      6'd37: r = e3(8'hE2, 8'h80, 8'hA2);
      6'd38: r = e3(8'hE2, 8'h9C, 8'h93);
      6'd39: r = e1(8'h0A);
      6'd40: r = e3(8'hE2, 8'h80, 8'hA6);
      6'd41: r = e1(8'hA0);
      6'd42: r = e1(8'hAE);
      6'd43: r = e1(8'h0D);
      6'd44: r = e1(8'h20);
      6'd45: r = e1(8'h09);
      6'd46: r = ep(PFX_UNI);
      6'd47: r = e1(8'h0B);
      6'd48: r = e3(8'hE2, 8'h80, 8'h94);
      6'd49: r = e3(8'hE2, 8'h80, 8'h89);
      6'd50: r = e3(8'hE2, 8'h80, 8'h82);
      6'd51: r = e3(8'hE2, 8'h80, 8'h83);
      6'd52: r = e1(8'h5C);
      6'd53: r = e1(8'h7C);
      6'd54: r = e1(8'h7E);
      6'd55: r = e1(8'h60);
      6'd56: r = e1(8'h22);
      6'd57: r = e1(8'h27);
      6'd58: r = e3(8'hE2, 8'h86, 8'h90);
      6'd59: r = e3(8'hE2, 8'h86, 8'h91);
      6'd60: r = e3(8'hE2, 8'h86, 8'h92);
      6'd61: r = e3(8'hE2, 8'h86, 8'h93);
      6'd62: r = e3(8'hE2, 8'h86, 8'h94);
      default: r = ep(PFX_END);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] normal_byte(input logic [SYM_W-1:0] s);
    logic [7:0] w;
    logic [7:0] r;
    w = {2'b00, s};
    if (s < 6'd26) begin
      r = w + 8'd65;
    end else if (s < 6'd52) begin
      r = w + 8'd71;
    end else if (s < 6'd62) begin
      r = w - 8'd4;
    end else begin
      r = 8'hF8;
    end
    return r;
  endfunction

  function automatic job_t utf8_job(input logic [31:0] cp);
    job_t r;
    r = '0;
    r.kind = KIND_TEXT;
    if (cp <= 32'h7F) begin
      r.cnt = 3'd1;
      r.bytes = {24'h0, cp[7:0]};
    end else if (cp <= 32'h7FF) begin
      r.cnt = 3'd2;
      r.bytes = {16'h0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
    end else if (cp <= 32'hFFFF) begin
      r.cnt = 3'd3;
      r.bytes = {8'h0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
    end else if (cp <= 32'h10FFFF) begin
      r.cnt = 3'd4;
      r.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
    end
    return r;
  endfunction

endpackage

### hw/rtl/sbtd_queue.sv
module sbtd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sbtd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output sbtd_pkg::job_t pop_job,
  output logic          avail
);
  import sbtd_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign avail   = (count != '0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

### hw/rtl/sbtd_front.sv
module sbtd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sbtd_pkg::SYM_W-1:0]   symbol,
  input  logic                         restart,
  output logic                         push,
  output sbtd_pkg::job_t               job,
  input  logic                         full
);
  import sbtd_pkg::*;

  localparam logic [2:0] M_NORMAL = 3'd0;
  localparam logic [2:0] M_ESCAPE = 3'd1;
  localparam logic [2:0] M_ULEN   = 3'd2;
  localparam logic [2:0] M_UDIG   = 3'd3;
  localparam logic [2:0] M_INT    = 3'd4;
  localparam logic [2:0] M_DBL    = 3'd5;
  localparam logic [2:0] M_DONE   = 3'd6;

  logic [2:0]      mode;
  logic [2:0]      mode_next;
  logic [DL_W-1:0] digits_left;
  logic [DL_W-1:0] digits_left_next;
  logic [63:0]     accumulator;
  logic [63:0]     accumulator_next;

  logic [2:0]      m;
  logic [DL_W-1:0] dl;
  logic [DL_W-1:0] dl_dec;
  logic [63:0]     acc;
  logic [31:0]     acc_u;
  logic [63:0]     acc_v;
  esc_t            esc;
  logic            accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (job.cnt != 3'd0);

  always_comb begin
    m   = restart ? M_NORMAL : mode;
    dl  = restart ? '0 : digits_left;
    acc = restart ? '0 : accumulator;
    dl_dec = (dl != '0) ? dl - 1'b1 : dl;
    acc_u  = {acc[31-SYM_W:0], symbol};
    acc_v  = {acc[63-SYM_W:0], symbol};
    esc    = esc_entry(symbol);
    mode_next        = m;
    digits_left_next = dl;
    accumulator_next = acc;
    job = '0;
    unique case (m) inside
      M_NORMAL: begin
        if (symbol == 6'd63) begin
          mode_next = M_ESCAPE;
        end else begin
          job.kind  = KIND_TEXT;
          job.cnt   = 3'd1;
          job.bytes = {24'h0, normal_byte(symbol)};
        end
      end
      M_ESCAPE: begin
        if (esc.len != 2'd0) begin
          job.kind  = KIND_TEXT;
          job.cnt   = {1'b0, esc.len};
          job.bytes = {8'h0, esc.bytes};
          mode_next = M_NORMAL;
        end else begin
          case (esc.pfx) inside
            PFX_UNI: mode_next = M_ULEN;
            PFX_INT, PFX_DBL: begin
              mode_next        = (esc.pfx == PFX_INT) ? M_INT : M_DBL;
              digits_left_next = DL_W'(VALUE_DIGITS);
              accumulator_next = '0;
            end
            default: begin
              job.kind  = KIND_END;
              job.cnt   = 3'd1;
              mode_next = M_DONE;
            end
          endcase
        end
      end
      M_ULEN: begin
        accumulator_next = '0;
        digits_left_next = symbol;
        if (symbol == '0) begin
          job       = utf8_job(32'h0);
          mode_next = M_NORMAL;
        end else begin
          mode_next = M_UDIG;
        end
      end
      M_UDIG: begin
        accumulator_next = {32'h0, acc_u};
        digits_left_next = dl_dec;
        if (dl_dec == '0) begin
          job       = utf8_job(acc_u);
          mode_next = M_NORMAL;
        end
      end
      M_INT, M_DBL: begin
        accumulator_next = acc_v;
        digits_left_next = dl_dec;
        if (dl_dec == '0) begin
          job.kind  = (m == M_INT) ? KIND_INT : KIND_DBL;
          job.cnt   = 3'd1;
          job.value = acc_v;
          mode_next = M_NORMAL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_NORMAL;
      digits_left <= '0;
      accumulator <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      digits_left <= digits_left_next;
      accumulator <= accumulator_next;
    end
  end

endmodule

### hw/rtl/sbtd_back.sv
module sbtd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_avail,
  input  sbtd_pkg::job_t job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_kind,
  output logic [7:0]     out_byte,
  output logic [63:0]    out_value,
  output logic           out_last
);
  import sbtd_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       taken;

  assign out_valid = cur_valid;
  assign out_kind  = cur.kind;
  assign out_byte  = cur.bytes[idx*8 +: 8];
  assign out_value = cur.value;
  assign out_last  = ({1'b0, idx} == cur.cnt - 3'd1);
  assign taken     = cur_valid && out_ready;
  assign pop       = job_avail && (!cur_valid || (taken && out_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (taken) begin
      if (out_last) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= job;
    end
  end

endmodule

### hw/rtl/six_bit_text_decoder.sv
// six-bit text decoder
// input stream: one 6-bit symbol per request on s_tdata, s_tuser set clears the
// decoder to normal mode before the symbol is decoded (start of a new message)
// output stream: one result per request; m_tuser gives the kind (text byte,
// integer value, double bit pattern, end of message), m_tdata the byte and
// the 64-bit value, m_tlast marks the final result caused by one symbol
// a symbol gives zero to four results; symbols that give none leave no trace
// on the output side
// a symbol's first result is registered in the queue, then in the output stage
// throughput: one symbol per cycle while the queue is not full, one result per
// cycle while m_tready is high; a four-entry request queue sits between the
// decode front and the output stage, so multi-byte results drain one byte a
// cycle while symbols keep arriving until it fills
// reset clears the decoder state, the queue and the output stage
// a stall on m_tready holds the current result; s_tready falls only once the
// queue is full
module six_bit_text_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // symbol [5:0], zero [7:6]
  input  logic        s_tuser,   // restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // out_byte [7:0], out_value [71:8]
  output logic [1:0]  m_tuser,   // out_kind
  output logic        m_tlast
);
  import sbtd_pkg::*;

  logic push;
  job_t push_job;
  logic full;
  logic pop;
  job_t pop_job;
  logic avail;
  logic [7:0]  out_byte;
  logic [63:0] out_value;

  sbtd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .symbol   (s_tdata[SYM_W-1:0]),
    .restart  (s_tuser),
    .push     (push),
    .job      (push_job),
    .full     (full)
  );

  sbtd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .avail    (avail)
  );

  sbtd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (avail),
    .job       (pop_job),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_byte  (out_byte),
    .out_value (out_value),
    .out_last  (m_tlast)
  );

  assign m_tdata = {out_value, out_byte};

endmodule

### hw/rtl/sbtd_checker.sv
`include "six_bit_text_decoder_macros.svh"

module sbtd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import sbtd_pkg::*;

  `SBTD_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `SBTD_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")
  `SBTD_ASSERT_NOW(a_value_single, m_tvalid && m_tuser != KIND_TEXT, m_tlast && m_tdata[7:0] == 8'h0, "value or end result not single")
  `SBTD_ASSERT_NOW(a_text_clean, m_tvalid && m_tuser == KIND_TEXT, m_tdata[71:8] == 64'h0, "text result carries a value")
  `SBTD_ASSERT_NOW(a_stall_busy, !s_tready, m_tvalid, "input stalled with no result pending")

endmodule

bind six_bit_text_decoder sbtd_checker u_sbtd_checker (.*);
